>>> sv/sorted_priority_queue_top_defines.svh
// Assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spq: assertion failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq: assertion failed");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/spq_pkg.sv
// Types and codes shared by the sorted priority queue modules
package spq_pkg;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_SERVE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_SERVED  = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [15:0]        entry_id;
    logic signed [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] served_id;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] prio;
    logic [15:0]        id;
  } slot_t;

  typedef struct packed {
    logic               ins;
    logic               srv;
    logic signed [15:0] prio;
    logic [15:0]        id;
  } cmd_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted chain: holds, shifts in from either neighbor, or takes the new entry
module spq_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::cmd_t  cmd_i,
  input  spq_pkg::slot_t left_i,
  input  logic          left_keep_i,
  input  spq_pkg::slot_t right_i,
  output spq_pkg::slot_t slot_o,
  output logic          keep_o
);
  import spq_pkg::*;

  slot_t slot_q, slot_d;

  assign keep_o = slot_q.valid && ($signed(slot_q.prio) >= $signed(cmd_i.prio));
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.srv) begin
      slot_d = right_i;
    end else if (cmd_i.ins) begin
      if (keep_o) begin
        slot_d = slot_q;
      end else if (left_keep_i) begin
        slot_d.valid = 1'b1;
        slot_d.prio  = cmd_i.prio;
        slot_d.id    = cmd_i.id;
      end else begin
        slot_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

>>> sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain and result register
//
//   channel   direction  payload            handshake
//   in        input      spq_pkg::in_item_t  in_valid_i / in_stall_o
//   out       output     spq_pkg::out_item_t out_valid_o / out_stall_i
//
// One request per cycle unless the input is stalled: each cell compares its slot
// with the broadcast priority and shifts, holds or loads along the chain.
// A result (serve, empty, dropped insert) is registered and shown in the cycle after transfer.
// Reset clears all slot valid flags; the queue starts empty.
// Input stalls only while a result waits in the output register under stall.
`include "sorted_priority_queue_top_defines.svh"
module sorted_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_item_t out_data_o
);
  import spq_pkg::*;

  slot_t                slot[CAPACITY];
  logic [CAPACITY-1:0]  keep;
  logic [CAPACITY-1:0]  occ_vec;
  logic [CAPACITY-1:0]  occ_inc;
  cmd_t                 cmd;
  logic                 in_acc;
  logic                 full;
  logic                 res_valid;
  out_item_t            res;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = occ_vec[CAPACITY-1];
  assign occ_inc    = occ_vec + {{(CAPACITY-1){1'b0}}, 1'b1};

  assign cmd.ins  = in_acc && (in_data_i.func == FUNC_INSERT) && !full;
  assign cmd.srv  = in_acc && (in_data_i.func == FUNC_SERVE) && occ_vec[0];
  assign cmd.prio = in_data_i.priority_req;
  assign cmd.id   = in_data_i.entry_id;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_keep;
    if (i == 0) begin : g_head
      assign left_s    = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_s    = slot[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slot[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_s),
      .left_keep_i (left_keep),
      .right_i     (right_s),
      .slot_o      (slot[i]),
      .keep_o      (keep[i])
    );
    assign occ_vec[i] = slot[i].valid;
  end

  always_comb begin
    res_valid     = 1'b0;
    res.status    = ST_SERVED;
    res.served_id = '0;
    unique case (in_data_i.func)
      FUNC_SERVE: begin
        res_valid = 1'b1;
        if (occ_vec[0]) begin
          res.status    = ST_SERVED;
          res.served_id = slot[0].id;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      FUNC_INSERT: begin
        if (full) begin
          res_valid  = 1'b1;
          res.status = ST_DROPPED;
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_acc) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = res;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SPQ_ASSERT(a_occ_prefix, (occ_vec & occ_inc) == '0)
  `SPQ_ASSERT(a_sorted_head, !slot[1].valid || ($signed(slot[0].prio) >= $signed(slot[1].prio)))
  `SPQ_ASSERT_NEXT(a_serve_result, cmd.srv, out_valid_o && (out_data_o.status == ST_SERVED))
  `SPQ_ASSERT_NEXT(a_insert_silent, cmd.ins, !out_valid_o)
  `SPQ_ASSERT_NEXT(a_insert_grows, cmd.ins, occ_vec[0])

endmodule
